// File: hw/rtl/ssdf_pkg.sv
// ----------------------------------------------------------------------------
// ssdf_pkg
// Shared types and constants of the supersample downscale filter.
// ----------------------------------------------------------------------------
package ssdf_pkg;

   localparam int DEF_MAX_OUT_WIDTH = 1024;
   localparam int STORED_ROWS       = 4;
   localparam int BANK_W            = $clog2(STORED_ROWS);
   localparam int QUEUE_DEPTH       = 4;
   localparam int QCOUNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam int PIXEL_W      = 32;
   localparam int COLOUR_W     = 24;
   localparam int CHAN_W       = 8;
   localparam int CHANNELS     = COLOUR_W / CHAN_W;
   localparam int OUT_COL_W    = 10;
   localparam int OUT_ROW_W    = 12;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int ROW_W        = 13;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 13;

   localparam int MAX_OUT_HEIGHT = 4096;

   localparam logic [WIDTH_REG_W-1:0]  RESET_OUT_WIDTH  = 11'd1024;
   localparam logic [HEIGHT_REG_W-1:0] RESET_OUT_HEIGHT = 13'd768;
   localparam logic [CHAN_W-1:0]       ALPHA_OPAQUE     = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_OUT_WIDTH  = 2'd0,
      CSR_OUT_HEIGHT = 2'd1,
      CSR_BYTE_ORDER = 2'd2
   } ssdf_csr_type;

   // what the back end does with one item
   typedef enum logic [1:0] {
      KIND_NONE      = 2'd0,
      KIND_BORDER_LO = 2'd1,   // 2x2 box over rows r-2, r-1
      KIND_BORDER_HI = 2'd2,   // 2x2 box over rows r-1, r
      KIND_INTERIOR  = 2'd3    // 12 tap filter over rows r-3 .. r
   } ssdf_kind_type;

   // one column of the four stored rows, youngest row first, plus its job
   typedef struct packed {
      logic [STORED_ROWS-1:0][COLOUR_W-1:0] cols;
      ssdf_kind_type                        kind;
      logic [OUT_COL_W-1:0]                 x;
      logic [OUT_ROW_W-1:0]                 y;
   } ssdf_entry_type;

endpackage

// File: hw/rtl/supersample_downscale_filter.sv
// ----------------------------------------------------------------------------
// supersample_downscale_filter
// 2x supersampled raster in, half-size anti-aliased raster out.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one 32-bit supersampled pixel per item, raster order, 2*out_width
//            pixels per row and 2*out_height rows per frame.
//   rsp_*  : one averaged pixel per item with its column and row; alpha 0xFF.
//   csr_*  : write out_width, out_height or byte_order while the block is idle;
//            any valid write restarts the frame at row 0, column 0.
// Throughput is one input item per cycle while req_stall is low; the line
// store takes one write and one four-lane read per cycle, and a four-entry
// queue sits between the classifying front end and the filter back end.
// A result shows on rsp_valid once the input item that completes its window
// has passed the line store read register, the queue, the filter and the
// output register. Interior pixels complete at an even input column, border
// pixels at an odd one; input rows 0 and 1 give no result.
// Reset empties the queue and output register and loads width 1024, height
// 768, byte order 0. When rsp_stall is high the result holds and the queue
// fills; req_stall rises once the queue has no room left.
// ----------------------------------------------------------------------------
module supersample_downscale_filter #(
   parameter int MAX_OUT_WIDTH = ssdf_pkg::DEF_MAX_OUT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssdf_pkg::PIXEL_W-1:0]      req_in_pixel,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [ssdf_pkg::PIXEL_W-1:0]      rsp_out_pixel,
   output logic [ssdf_pkg::OUT_COL_W-1:0]    rsp_out_col,
   output logic [ssdf_pkg::OUT_ROW_W-1:0]    rsp_out_row,
   input  logic                              csr_write_en,
   input  logic [ssdf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssdf_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ssdf_pkg::*;

   logic                q_push;
   ssdf_entry_type      q_entry;
   logic                q_pop;
   ssdf_entry_type      q_head;
   logic                q_head_valid;
   logic [QCOUNT_W-1:0] q_count;
   logic                byte_order;

   ssdf_front #(
      .MAX_OUT_WIDTH(MAX_OUT_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_in_pixel (req_in_pixel),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_count      (q_count),
      .push_valid   (q_push),
      .push_entry   (q_entry),
      .byte_order   (byte_order)
   );

   ssdf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_entry),
      .pop        (q_pop),
      .head       (q_head),
      .head_valid (q_head_valid),
      .count      (q_count)
   );

   ssdf_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_valid    (q_head_valid),
      .head          (q_head),
      .pop           (q_pop),
      .byte_order    (byte_order),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_pixel (rsp_out_pixel),
      .rsp_out_col   (rsp_out_col),
      .rsp_out_row   (rsp_out_row)
   );

`ifndef ASSERT_OFF
   // credit check keeps the queue from overflowing
   a_queue_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_count < QUEUE_DEPTH))
      else $error("queue push without room");

   a_accept_reaches_queue: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> q_push)
      else $error("accepted item did not reach the queue");

   a_result_from_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(q_pop))
      else $error("result shown without a queue pop");
`endif

endmodule

// File: hw/rtl/ssdf_front.sv
// ----------------------------------------------------------------------------
// ssdf_front
// Input side: registers, position counters, classification and line store.
// ----------------------------------------------------------------------------
module ssdf_front #(
   parameter int MAX_OUT_WIDTH = ssdf_pkg::DEF_MAX_OUT_WIDTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ssdf_pkg::PIXEL_W-1:0]      req_in_pixel,
   input  logic                              csr_write_en,
   input  logic [ssdf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [ssdf_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic [ssdf_pkg::QCOUNT_W-1:0]     q_count,
   output logic                              push_valid,
   output ssdf_pkg::ssdf_entry_type          push_entry,
   output logic                              byte_order
);
   import ssdf_pkg::*;

   localparam int LINE_SLOTS = 2 * MAX_OUT_WIDTH;
   localparam int COL_W      = $clog2(LINE_SLOTS);
   localparam int WID_W      = $clog2(MAX_OUT_WIDTH + 1);

   logic [WIDTH_REG_W-1:0]  out_width_ff, out_width_in;
   logic [HEIGHT_REG_W-1:0] out_height_ff, out_height_in;
   logic                    byte_order_ff, byte_order_in;
   logic                    cfg_restart;

   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   logic [WID_W-1:0] eff_w;
   logic [ROW_W-1:0] eff_h;
   logic [COL_W-1:0] col_last;
   logic [ROW_W-1:0] row_last;

   logic                 accept;
   logic [COLOUR_W-1:0]  colour;
   logic [COL_W-2:0]     col_half;
   logic [COL_W-2:0]     x_full;
   logic [ROW_W-1:0]     y_full;
   logic                 last_row, out_row, top_row;
   ssdf_kind_type        kind;

   logic [STORED_ROWS-1:0][COLOUR_W-1:0] line_mem [LINE_SLOTS];
   logic [STORED_ROWS-1:0][COLOUR_W-1:0] rd_ff;

   logic                 s1_valid_ff;
   logic [COLOUR_W-1:0]  s1_colour_ff;
   logic [BANK_W-1:0]    s1_bank_ff;
   ssdf_kind_type        s1_kind_ff;
   logic [OUT_COL_W-1:0] s1_x_ff;
   logic [OUT_ROW_W-1:0] s1_y_ff;

   // ---------------- configuration
   always_comb begin
      out_width_in  = out_width_ff;
      out_height_in = out_height_ff;
      byte_order_in = byte_order_ff;
      cfg_restart   = 1'b0;
      if (csr_write_en) begin
         case (csr_index)
            CSR_OUT_WIDTH: begin
               out_width_in = csr_wdata[WIDTH_REG_W-1:0];
               cfg_restart  = 1'b1;
            end
            CSR_OUT_HEIGHT: begin
               out_height_in = csr_wdata[HEIGHT_REG_W-1:0];
               cfg_restart   = 1'b1;
            end
            CSR_BYTE_ORDER: begin
               byte_order_in = csr_wdata[0];
               cfg_restart   = 1'b1;
            end
            default: begin
               cfg_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_width_ff  <= RESET_OUT_WIDTH;
         out_height_ff <= RESET_OUT_HEIGHT;
         byte_order_ff <= 1'b0;
      end else begin
         out_width_ff  <= out_width_in;
         out_height_ff <= out_height_in;
         byte_order_ff <= byte_order_in;
      end
   end

   assign byte_order = byte_order_ff;

   // clamped frame size
   always_comb begin
      if (out_width_ff < 2)
         eff_w = WID_W'(2);
      else if (out_width_ff > MAX_OUT_WIDTH)
         eff_w = WID_W'(MAX_OUT_WIDTH);
      else
         eff_w = WID_W'(out_width_ff);

      if (out_height_ff < 2)
         eff_h = ROW_W'(2);
      else if (out_height_ff > MAX_OUT_HEIGHT)
         eff_h = ROW_W'(MAX_OUT_HEIGHT);
      else
         eff_h = ROW_W'(out_height_ff);

      col_last = COL_W'({eff_w, 1'b0} - 1'b1);
      row_last = ROW_W'({eff_h, 1'b0} - 1'b1);
   end

   // ---------------- input handshake and counters
   assign req_stall = ({1'b0, q_count} + (QCOUNT_W + 1)'(s1_valid_ff)) >= QUEUE_DEPTH;
   assign accept    = req_valid && !req_stall;
   assign colour    = byte_order_ff ? req_in_pixel[PIXEL_W-1:CHAN_W]
                                    : req_in_pixel[COLOUR_W-1:0];

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (cfg_restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (col_ff == col_last) begin
            col_in = '0;
            row_in = (row_ff == row_last) ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------- classification
   always_comb begin
      col_half = col_ff[COL_W-1:1];
      last_row = row_ff == row_last;
      out_row  = !row_ff[0] && (row_ff[ROW_W-1:1] != '0);
      top_row  = row_ff == ROW_W'(2);
      kind     = KIND_NONE;
      x_full   = col_half;
      if (last_row) begin
         if (col_ff[0])
            kind = KIND_BORDER_HI;
      end else if (out_row) begin
         if (col_ff[0]) begin
            if (top_row || col_half == '0 || col_half == (eff_w - 1'b1))
               kind = KIND_BORDER_LO;
         end else if (!top_row && col_ff >= 4) begin
            kind   = KIND_INTERIOR;
            x_full = col_half - 1'b1;
         end
      end
      y_full = last_row ? ROW_W'(eff_h - 1'b1) : ROW_W'((row_ff >> 1) - 1'b1);
   end

   // ---------------- line store, one lane per stored row
   always_ff @(posedge clock) begin
      if (accept) begin
         line_mem[col_ff][row_ff[BANK_W-1:0]] <= colour;
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else
         s1_valid_ff <= accept;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_colour_ff <= colour;
         s1_bank_ff   <= row_ff[BANK_W-1:0];
         s1_kind_ff   <= kind;
         s1_x_ff      <= OUT_COL_W'(x_full);
         s1_y_ff      <= OUT_ROW_W'(y_full);
      end
   end

   // rotate lanes so that slot d holds row r-d
   always_comb begin
      push_entry.cols[0] = s1_colour_ff;
      for (int d = 1; d < STORED_ROWS; d++)
         push_entry.cols[d] = rd_ff[s1_bank_ff - BANK_W'(d)];
      push_entry.kind = s1_kind_ff;
      push_entry.x    = s1_x_ff;
      push_entry.y    = s1_y_ff;
   end

   assign push_valid = s1_valid_ff;

endmodule

// File: hw/rtl/ssdf_queue.sv
// ----------------------------------------------------------------------------
// ssdf_queue
// Short queue of column items between the front and the back end.
// ----------------------------------------------------------------------------
module ssdf_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  ssdf_pkg::ssdf_entry_type      push_entry,
   input  logic                          pop,
   output ssdf_pkg::ssdf_entry_type      head,
   output logic                          head_valid,
   output logic [ssdf_pkg::QCOUNT_W-1:0] count
);
   import ssdf_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   ssdf_entry_type      slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_entry;
   end

   assign head       = slot_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;
   assign count      = count_ff;

endmodule

// File: hw/rtl/ssdf_back.sv
// ----------------------------------------------------------------------------
// ssdf_back
// Output side: 4x4 sample window, box and 12 tap filter, result register.
// ----------------------------------------------------------------------------
module ssdf_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            head_valid,
   input  ssdf_pkg::ssdf_entry_type        head,
   output logic                            pop,
   input  logic                            byte_order,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [ssdf_pkg::PIXEL_W-1:0]    rsp_out_pixel,
   output logic [ssdf_pkg::OUT_COL_W-1:0]  rsp_out_col,
   output logic [ssdf_pkg::OUT_ROW_W-1:0]  rsp_out_row
);
   import ssdf_pkg::*;

   localparam int WIN_COLS = 3;           // columns c-1 .. c-3
   localparam int VIEW_COLS = WIN_COLS + 1;
   localparam int SUM_W = CHAN_W + 4;

   logic [STORED_ROWS-1:0][WIN_COLS-1:0][COLOUR_W-1:0]  win_ff, win_in;
   logic [STORED_ROWS-1:0][VIEW_COLS-1:0][COLOUR_W-1:0] view;

   logic [SUM_W-1:0]    sum;
   logic [COLOUR_W-1:0] colour;
   logic [PIXEL_W-1:0]  pixel;
   logic                have;

   logic                 out_valid_ff, out_valid_in;
   logic [PIXEL_W-1:0]   out_pixel_ff;
   logic [OUT_COL_W-1:0] out_col_ff;
   logic [OUT_ROW_W-1:0] out_row_ff;

   function automatic logic [SUM_W-1:0] chan(input logic [COLOUR_W-1:0] v, input int i);
      return SUM_W'(v[i*CHAN_W +: CHAN_W]);
   endfunction

   assign have = head.kind != KIND_NONE;
   assign pop  = head_valid && (!have || !out_valid_ff || !rsp_stall);

   // view[d][k]: row r-d, column c-k
   always_comb begin
      for (int d = 0; d < STORED_ROWS; d++) begin
         view[d][0] = head.cols[d];
         for (int k = 1; k < VIEW_COLS; k++)
            view[d][k] = win_ff[d][k-1];
      end
   end

   always_comb begin
      colour = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         sum = '0;
         case (head.kind)
            KIND_INTERIOR: begin
               sum = chan(view[3][2], i) + chan(view[3][1], i)
                   + chan(view[2][3], i) + (chan(view[2][2], i) << 1)
                   + (chan(view[2][1], i) << 1) + chan(view[2][0], i)
                   + chan(view[1][3], i) + (chan(view[1][2], i) << 1)
                   + (chan(view[1][1], i) << 1) + chan(view[1][0], i)
                   + chan(view[0][2], i) + chan(view[0][1], i);
               colour[i*CHAN_W +: CHAN_W] = sum[SUM_W-1:4];
            end
            KIND_BORDER_LO: begin
               sum = chan(view[2][1], i) + chan(view[2][0], i)
                   + chan(view[1][1], i) + chan(view[1][0], i);
               colour[i*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
            end
            KIND_BORDER_HI: begin
               sum = chan(view[1][1], i) + chan(view[1][0], i)
                   + chan(view[0][1], i) + chan(view[0][0], i);
               colour[i*CHAN_W +: CHAN_W] = sum[CHAN_W+1:2];
            end
            default: begin
               sum = '0;
            end
         endcase
      end
      pixel = byte_order ? {colour, ALPHA_OPAQUE} : {ALPHA_OPAQUE, colour};
   end

   // every item shifts the window, result or not
   always_comb begin
      win_in = win_ff;
      if (pop) begin
         for (int d = 0; d < STORED_ROWS; d++) begin
            win_in[d][0] = head.cols[d];
            for (int k = 1; k < WIN_COLS; k++)
               win_in[d][k] = win_ff[d][k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end

   always_comb begin
      if (pop && have)
         out_valid_in = 1'b1;
      else if (!rsp_stall)
         out_valid_in = 1'b0;
      else
         out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset)
         out_valid_ff <= 1'b0;
      else
         out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop && have) begin
         out_pixel_ff <= pixel;
         out_col_ff   <= head.x;
         out_row_ff   <= head.y;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_out_pixel = out_pixel_ff;
   assign rsp_out_col   = out_col_ff;
   assign rsp_out_row   = out_row_ff;

endmodule
